/* src/sf_pkg.sv */
// Package with shared widths and the data records that travel between the cells.
`timescale 1ns / 1ps

package sf_pkg;

	localparam int IDX_W = 12;
	localparam int POS_W = 32;
	localparam int DIF_W = 33;
	localparam int SQ_W = 67;
	localparam int ROOT_W = 33;
	localparam int DV_W = 49;
	localparam int LANES = 3;

	typedef struct packed {
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic [LANES-1:0][DIF_W-1:0] ad;
		logic [LANES-1:0] dsign;
		logic [POS_W-1:0] stiff;
		logic [POS_W-1:0] rest;
	} sf_side_t;

	typedef struct packed {
		logic [SQ_W-1:0] r;
		logic [ROOT_W-1:0] root;
		sf_side_t side;
	} sf_sqrt_t;

	typedef struct packed {
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic [LANES-1:0] neg;
		logic [LANES-1:0] sat;
		logic zero;
		logic [DV_W-1:0] dv;
		logic [LANES-1:0][DV_W-1:0] rem;
		logic [LANES-1:0][ROOT_W-1:0] lo;
	} sf_div_t;

endpackage

/* src/sf_if.sv */
// Stream interfaces for spring words and force words.
`timescale 1ns / 1ps

interface sf_in_if;
	logic valid;
	logic ready;
	logic [11:0] first_index;
	logic [11:0] second_index;
	logic signed [31:0] first_x;
	logic signed [31:0] first_y;
	logic signed [31:0] first_z;
	logic signed [31:0] second_x;
	logic signed [31:0] second_y;
	logic signed [31:0] second_z;
	logic [31:0] stiffness;
	logic [31:0] rest_length;

	modport source (output valid, first_index, second_index, first_x, first_y, first_z,
		second_x, second_y, second_z, stiffness, rest_length, input ready);
	modport sink (input valid, first_index, second_index, first_x, first_y, first_z,
		second_x, second_y, second_z, stiffness, rest_length, output ready);
endinterface

interface sf_out_if;
	logic valid;
	logic ready;
	logic [11:0] out_first_index;
	logic [11:0] out_second_index;
	logic signed [31:0] force_x;
	logic signed [31:0] force_y;
	logic signed [31:0] force_z;

	modport source (output valid, out_first_index, out_second_index, force_x, force_y,
		force_z, input ready);
	modport sink (input valid, out_first_index, out_second_index, force_x, force_y,
		force_z, output ready);
endinterface

/* src/sf_sqrt_cell.sv */
// One bit cell of the pipelined integer square root.
`timescale 1ns / 1ps

module sf_sqrt_cell import sf_pkg::*; #(
	parameter int BIT = 0
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sf_sqrt_t in_data,
	output logic out_valid,
	output sf_sqrt_t out_data
);

	localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << (2 * BIT);
	localparam logic [ROOT_W-1:0] ONE_RT = ROOT_W'(1) << BIT;

	logic [SQ_W-1:0] trial;
	logic take;
	sf_sqrt_t nxt;
	logic valid_q;
	sf_sqrt_t data_q;

	always_comb begin
		trial = ({{(SQ_W-ROOT_W){1'b0}}, in_data.root} << (BIT + 1)) + ONE_SQ;
		take = (trial <= in_data.r);
		nxt = in_data;
		if (take) begin
			nxt.r = in_data.r - trial;
			nxt.root = in_data.root | ONE_RT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

/* src/sf_div_cell.sv */
// One quotient bit cell of the restoring divider, three lanes side by side.
`timescale 1ns / 1ps

module sf_div_cell import sf_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sf_div_t in_data,
	output logic out_valid,
	output sf_div_t out_data
);

	logic [DV_W:0] r2 [LANES];
	logic [DV_W:0] diff [LANES];
	logic take [LANES];
	sf_div_t nxt;
	logic valid_q;
	sf_div_t data_q;

	always_comb begin
		nxt = in_data;
		for (int i = 0; i < LANES; i++) begin
			r2[i] = {in_data.rem[i], in_data.lo[i][ROOT_W-1]};
			diff[i] = r2[i] - {1'b0, in_data.dv};
			take[i] = (r2[i] >= {1'b0, in_data.dv});
			nxt.rem[i] = take[i] ? diff[i][DV_W-1:0] : r2[i][DV_W-1:0];
			nxt.lo[i] = {in_data.lo[i][ROOT_W-2:0], take[i]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data = data_q;

endmodule

/* src/spring_force.sv */
// Hooke spring force pipeline: a row of square root cells, multipliers, a row of divider cells.
// Usage:
// Spring words enter spring_in, one per cycle unless stalled; force words exit force_out in the
// same order, one for each spring word. A word is taken when valid and ready are both high.
// Each force word carries both endpoint indices and the force on the first endpoint in
// signed Q16.16, saturated per component; the second endpoint receives its negation.
// Coincident endpoints give zero force.
// From acceptance to force_out a word passes the registers for differences, squares and
// their sum, 33 square root cells, the registers that form the numerator, 33 divider cells
// and the output register.
// Throughput is one spring word per cycle while force_out is not stalled, set by the rows of
// cells that each hand their word to the next one every cycle.
// When the receiver holds ready low while a force word waits, the whole pipeline holds and
// spring_in.ready drops in the same cycle; nothing is lost or repeated.
// Reset clears all valid flags; the pipeline is empty and ready right after reset.
`timescale 1ns / 1ps

module spring_force import sf_pkg::*; (
	input logic clk,
	input logic arst_n,
	sf_in_if.sink spring_in,
	sf_out_if.source force_out
);

	localparam int NCELL = ROOT_W;

	logic en;
	logic out_valid_q;

	logic signed [DIF_W:0] dif [LANES];
	logic valid_s1, valid_s2, valid_s3;
	sf_side_t side_s1, side_s2, side_s3;
	logic [2*DIF_W-1:0] sq_s2 [LANES];
	logic [SQ_W-1:0] sum_s3;

	logic sq_v [NCELL+1];
	sf_sqrt_t sq_d [NCELL+1];

	logic [DIF_W+POS_W-1:0] prod_a [LANES];
	logic [DIF_W-1:0] ln, adelta;
	logic dneg;
	logic valid_a, valid_b, valid_c;
	logic [IDX_W-1:0] fi_a, si_a, fi_b, si_b;
	logic [LANES-1:0] neg_a, neg_b;
	logic zero_a, zero_b;
	logic [DV_W-1:0] dv_a, dv_b;
	logic [DIF_W-1:0] adelta_a;
	logic [63:0] p1_a [LANES];
	logic [64:0] pl_b [LANES];
	logic [64:0] ph_b [LANES];
	logic [96:0] num [LANES];
	sf_div_t div_c;

	logic dv_v [NCELL+1];
	sf_div_t dv_d [NCELL+1];

	logic [POS_W-1:0] frc [LANES];
	logic [POS_W-1:0] frc_q [LANES];
	logic [IDX_W-1:0] fi_q, si_q;
	logic [ROOT_W-1:0] q;
	logic big;

	assign en = !out_valid_q || force_out.ready;
	assign spring_in.ready = en;

	always_comb begin
		dif[0] = (DIF_W+1)'(spring_in.first_x) - (DIF_W+1)'(spring_in.second_x);
		dif[1] = (DIF_W+1)'(spring_in.first_y) - (DIF_W+1)'(spring_in.second_y);
		dif[2] = (DIF_W+1)'(spring_in.first_z) - (DIF_W+1)'(spring_in.second_z);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_a <= 1'b0;
			valid_b <= 1'b0;
			valid_c <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1 <= spring_in.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_a <= sq_v[NCELL];
			valid_b <= valid_a;
			valid_c <= valid_b;
			out_valid_q <= dv_v[NCELL];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1.first_index <= spring_in.first_index;
			side_s1.second_index <= spring_in.second_index;
			side_s1.stiff <= spring_in.stiffness;
			side_s1.rest <= spring_in.rest_length;
			for (int i = 0; i < LANES; i++) begin
				side_s1.dsign[i] <= dif[i][DIF_W];
				side_s1.ad[i] <= dif[i][DIF_W] ? DIF_W'(-dif[i]) : dif[i][DIF_W-1:0];
			end
			side_s2 <= side_s1;
			for (int i = 0; i < LANES; i++) begin
				sq_s2[i] <= side_s1.ad[i] * side_s1.ad[i];
			end
			side_s3 <= side_s2;
			sum_s3 <= SQ_W'(sq_s2[0]) + SQ_W'(sq_s2[1]) + SQ_W'(sq_s2[2]);
		end
	end

	always_comb begin
		sq_v[0] = valid_s3;
		sq_d[0].r = sum_s3;
		sq_d[0].root = '0;
		sq_d[0].side = side_s3;
	end

	for (genvar k = 0; k < NCELL; k++) begin : g_sqrt
		sf_sqrt_cell #(.BIT(NCELL - 1 - k)) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(sq_v[k]),
			.in_data(sq_d[k]),
			.out_valid(sq_v[k+1]),
			.out_data(sq_d[k+1])
		);
	end

	always_comb begin
		ln = sq_d[NCELL].root;
		dneg = ln < {1'b0, sq_d[NCELL].side.rest};
		adelta = dneg ? {1'b0, sq_d[NCELL].side.rest} - ln : ln - {1'b0, sq_d[NCELL].side.rest};
		for (int i = 0; i < LANES; i++) begin
			prod_a[i] = sq_d[NCELL].side.stiff * sq_d[NCELL].side.ad[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fi_a <= sq_d[NCELL].side.first_index;
			si_a <= sq_d[NCELL].side.second_index;
			zero_a <= (ln == '0);
			dv_a <= {ln, 16'h0000};
			adelta_a <= adelta;
			for (int i = 0; i < LANES; i++) begin
				neg_a[i] <= (dneg == sq_d[NCELL].side.dsign[i]);
				p1_a[i] <= prod_a[i][63:0];
			end
			fi_b <= fi_a;
			si_b <= si_a;
			zero_b <= zero_a;
			dv_b <= dv_a;
			neg_b <= neg_a;
			for (int i = 0; i < LANES; i++) begin
				pl_b[i] <= p1_a[i][31:0] * adelta_a;
				ph_b[i] <= p1_a[i][63:32] * adelta_a;
			end
		end
	end

	always_comb begin
		div_c.first_index = fi_b;
		div_c.second_index = si_b;
		div_c.neg = neg_b;
		div_c.zero = zero_b;
		div_c.dv = dv_b;
		for (int i = 0; i < LANES; i++) begin
			num[i] = {32'h0, pl_b[i]} + {ph_b[i], 32'h0};
			div_c.sat[i] = (num[i][96:33] >= {15'h0, dv_b});
			div_c.rem[i] = (div_c.sat[i] || zero_b) ? '0 : num[i][81:33];
			div_c.lo[i] = num[i][32:0];
		end
	end

	sf_div_t div_c_q;

	always_ff @(posedge clk) begin
		if (en) begin
			div_c_q <= div_c;
		end
	end

	always_comb begin
		dv_v[0] = valid_c;
		dv_d[0] = div_c_q;
	end

	for (genvar k = 0; k < NCELL; k++) begin : g_div
		sf_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.in_valid(dv_v[k]),
			.in_data(dv_d[k]),
			.out_valid(dv_v[k+1]),
			.out_data(dv_d[k+1])
		);
	end

	always_comb begin
		q = '0;
		big = 1'b0;
		for (int i = 0; i < LANES; i++) begin
			q = dv_d[NCELL].lo[i];
			big = dv_d[NCELL].sat[i] ||
				(dv_d[NCELL].neg[i] ? (q > 33'h080000000) : (q > 33'h07FFFFFFF));
			if (dv_d[NCELL].zero) begin
				frc[i] = '0;
			end else if (big) begin
				frc[i] = dv_d[NCELL].neg[i] ? 32'h80000000 : 32'h7FFFFFFF;
			end else begin
				frc[i] = dv_d[NCELL].neg[i] ? (~q[31:0] + 32'd1) : q[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fi_q <= dv_d[NCELL].first_index;
			si_q <= dv_d[NCELL].second_index;
			for (int i = 0; i < LANES; i++) begin
				frc_q[i] <= frc[i];
			end
		end
	end

	assign force_out.valid = out_valid_q;
	assign force_out.out_first_index = fi_q;
	assign force_out.out_second_index = si_q;
	assign force_out.force_x = frc_q[0];
	assign force_out.force_y = frc_q[1];
	assign force_out.force_z = frc_q[2];

`ifndef ASSERT_OFF
	a_sqrt_floor: assert property (@(posedge clk) disable iff (!arst_n)
		sq_v[NCELL] |-> (sq_d[NCELL].r <= {{(SQ_W-ROOT_W-1){1'b0}}, sq_d[NCELL].root, 1'b0}))
		else $error("Square root remainder exceeds twice the root.");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(dv_v[NCELL] && !dv_d[NCELL].zero) |->
		(dv_d[NCELL].rem[0] < dv_d[NCELL].dv && dv_d[NCELL].rem[1] < dv_d[NCELL].dv &&
		dv_d[NCELL].rem[2] < dv_d[NCELL].dv))
		else $error("Divider remainder not below divisor.");
	a_zero_len: assert property (@(posedge clk) disable iff (!arst_n)
		(en && dv_v[NCELL] && dv_d[NCELL].zero) |=> (force_out.force_x == '0 &&
		force_out.force_y == '0 && force_out.force_z == '0))
		else $error("Zero length spring gave nonzero force.");
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!spring_in.ready |-> (force_out.valid && !force_out.ready))
		else $error("Input stalled without a waiting force word.");
`endif

endmodule

/* verif/spring_force_test.sv */
// Self-checking bench for the spring force pipeline: a table of directed springs, then random ones.
`timescale 1ns / 1ps

module spring_force_test;
	import sf_pkg::*;

	typedef struct packed {
		logic [11:0] fi;
		logic [11:0] si;
		logic signed [31:0] ax, ay, az, bx, by, bz;
		logic [31:0] k, rest;
	} spring_t;

	typedef struct packed {
		logic [11:0] fi;
		logic [11:0] si;
		logic signed [31:0] fx, fy, fz;
	} force_t;

	typedef struct {
		spring_t s;
		bit known;
		force_t f;
	} row_t;

	logic clk;
	logic arst_n;
	sf_in_if spring_in();
	sf_out_if force_out();

	spring_force i_dut (.clk(clk), .arst_n(arst_n), .spring_in(spring_in),
		.force_out(force_out));

	force_t pending_forces[$];
	int errors = 0;
	bit quiet_mode = 0;
	row_t dir_rows[$];

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [32:0] int_root(logic [66:0] sq);
		logic [32:0] r;
		logic [32:0] c;
		r = 0;
		for (int b = 32; b >= 0; b--) begin
			c = r | (33'd1 << b);
			if ({67'd0, c} * {67'd0, c} <= {67'd0, sq}) r = c;
		end
		return r;
	endfunction

	function automatic force_t spring_force_of(spring_t s);
		force_t f;
		logic signed [33:0] d[3];
		logic [33:0] ad[3];
		logic [66:0] sq;
		logic [32:0] len;
		logic [32:0] adelta;
		logic [127:0] num, q;
		logic [31:0] comp[3];
		bit shorter, neg;
		d[0] = 34'(s.ax) - 34'(s.bx);
		d[1] = 34'(s.ay) - 34'(s.by);
		d[2] = 34'(s.az) - 34'(s.bz);
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			ad[i] = d[i] < 0 ? -d[i] : d[i];
			sq += {33'd0, ad[i]} * {33'd0, ad[i]};
		end
		len = int_root(sq);
		shorter = len < {1'b0, s.rest};
		adelta = shorter ? {1'b0, s.rest} - len : len - {1'b0, s.rest};
		for (int i = 0; i < 3; i++) begin
			if (len == 0) begin
				comp[i] = 0;
			end else begin
				num = {96'd0, s.k} * {94'd0, ad[i]} * {95'd0, adelta};
				q = num / ({95'd0, len} << 16);
				neg = (shorter == (d[i] < 0));
				if (neg) comp[i] = (q > 128'h80000000) ? 32'h80000000 : 32'(-q);
				else comp[i] = (q > 128'h7FFFFFFF) ? 32'h7FFFFFFF : q[31:0];
			end
		end
		f.fi = s.fi;
		f.si = s.si;
		f.fx = comp[0];
		f.fy = comp[1];
		f.fz = comp[2];
		return f;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
			2: return 32'($signed($urandom_range(0, 200)) - 100) << 16;
			default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
		endcase
	endfunction

	function automatic spring_t rand_spring();
		spring_t s;
		s.fi = 12'($urandom);
		s.si = 12'($urandom);
		s.ax = rand_coord();
		s.ay = rand_coord();
		s.az = rand_coord();
		if ($urandom_range(0, 9) == 0) begin
			s.bx = s.ax;
			s.by = s.ay;
			s.bz = s.az;
		end else begin
			s.bx = rand_coord();
			s.by = rand_coord();
			s.bz = rand_coord();
		end
		s.k = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000A0000);
		s.rest = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00400000);
		return s;
	endfunction

	task automatic send_spring(spring_t s, bit known, force_t f);
		while (!quiet_mode && $urandom_range(0, 99) < 30) begin
			spring_in.valid <= 0;
			@(posedge clk);
		end
		spring_in.valid <= 1;
		{spring_in.first_index, spring_in.second_index, spring_in.first_x,
			spring_in.first_y, spring_in.first_z, spring_in.second_x, spring_in.second_y,
			spring_in.second_z, spring_in.stiffness, spring_in.rest_length} <= s;
		@(posedge clk);
		while (!spring_in.ready) @(posedge clk);
		pending_forces.push_back(known ? f : spring_force_of(s));
	endtask

	task automatic add_row(spring_t s, bit known, force_t f);
		row_t r;
		r.s = s;
		r.known = known;
		r.f = f;
		dir_rows.push_back(r);
	endtask

	always @(posedge clk) begin
		if (force_out.valid && force_out.ready) begin
			force_t got, want;
			got = {force_out.out_first_index, force_out.out_second_index,
				force_out.force_x, force_out.force_y, force_out.force_z};
			if (pending_forces.size() == 0) begin
				errors++;
				$display("%0t: unexpected force word %h", $time, got);
			end else begin
				want = pending_forces.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t: expected %h %h %h %h %h, actual %h %h %h %h %h", $time,
						want.fi, want.si, want.fx, want.fy, want.fz,
						got.fi, got.si, got.fx, got.fy, got.fz);
				end
			end
		end
		force_out.ready <= quiet_mode || ($urandom_range(0, 99) >= 30);
	end

	initial begin
		spring_t s;
		force_t f;
		int waited;
		spring_in.valid = 0;
		{spring_in.first_index, spring_in.second_index, spring_in.first_x,
			spring_in.first_y, spring_in.first_z, spring_in.second_x, spring_in.second_y,
			spring_in.second_z, spring_in.stiffness, spring_in.rest_length} = '0;
		force_out.ready = 0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;

		s = '0;
		f = '0;
		add_row(s, 1, f);
		s = '{12'hFFF, 12'h000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
		f = '{12'hFFF, 12'h000, 0, 0, 0};
		add_row(s, 1, f);
		s = '{12'h000, 12'hFFF, 32'h00010000, 0, 0, 0, 0, 0, 32'h00010000, 0};
		f = '{12'h000, 12'hFFF, 32'hFFFF0000, 0, 0};
		add_row(s, 1, f);
		s = '{12'h123, 12'h456, 32'h00010000, 0, 0, 0, 0, 0, 32'h00010000, 32'h00010000};
		f = '{12'h123, 12'h456, 0, 0, 0};
		add_row(s, 1, f);
		s = '{12'hAAA, 12'h555, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h80000000, 32'h80000000, 32'h80000000, 32'hFFFFFFFF, 0};
		f = '{12'hAAA, 12'h555, 32'h80000000, 32'h80000000, 32'h80000000};
		add_row(s, 1, f);
		s = '{12'h555, 12'hAAA, 32'h80000000, 32'h80000000, 32'h80000000,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 0};
		f = '{12'h555, 12'hAAA, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF};
		add_row(s, 1, f);
		s = '{12'd7, 12'd9, 0, 0, 32'h00020000, 0, 0, 0, 32'h00030000, 32'hFFFFFFFF};
		add_row(s, 0, '0);
		s = '{12'd1, 12'd2, 32'h00030000, 32'hFFFC0000, 0, 0, 0, 0, 32'h00020000,
			32'h00010000};
		add_row(s, 0, '0);
		s = '{12'd3, 12'd4, 1, 0, 0, 0, 0, 0, 32'hFFFFFFFF, 0};
		add_row(s, 0, '0);
		s = '{12'd5, 12'd6, 32'hFFFFFFFF, 32'h12345678, 32'hEDCBA987, 0, 0, 0,
			32'h0001_8000, 32'h0800_0000};
		add_row(s, 0, '0);
		foreach (dir_rows[i]) send_spring(dir_rows[i].s, dir_rows[i].known, dir_rows[i].f);

		for (int n = 0; n < 950; n++) begin
			quiet_mode = (n >= 300 && n < 400);
			if (n == 600) begin
				spring_in.valid <= 0;
				@(posedge clk);
				while (pending_forces.size() != 0) @(posedge clk);
			end
			send_spring(rand_spring(), 0, '0);
		end
		quiet_mode = 0;
		spring_in.valid <= 0;

		waited = 0;
		while (pending_forces.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (100) @(posedge clk);
		if (errors == 0 && pending_forces.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* files.f */
src/sf_pkg.sv
src/sf_if.sv
src/sf_sqrt_cell.sv
src/sf_div_cell.sv
src/spring_force.sv
verif/spring_force_test.sv
